// ===== rtl/esseg_pkg.sv =====
// ----------------------------------------------------------------------------
// esseg_pkg
// shared constants, codes and types of the energy speech segmenter
// ----------------------------------------------------------------------------
package esseg_pkg;

	// default largest packet, in samples
	localparam int unsigned PACKET_MAX_DEF  = 4096;
	// depth of the packet queue between front and back
	localparam int unsigned QUEUE_DEPTH_DEF = 4;
	// sample width the energy path is built for
	localparam int unsigned SAMPLE_BITS     = 16;

	localparam int unsigned SAMPLE_W  = 16;
	localparam int unsigned THR_W     = 16;
	localparam int unsigned TCFG_W    = 24;
	localparam int unsigned TIME_W    = 25;
	localparam int unsigned LEN_W     = 26;
	localparam int unsigned CFG_W     = 24;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned SQ_W      = 31;
	localparam int unsigned THR_SQ_W  = 32;
	localparam int unsigned S_DATA_W  = 24;
	localparam int unsigned M_DATA_W  = 32;

	// register reset values
	localparam logic [THR_W-1:0]  THR_RST     = 16'd9830;
	localparam logic [TCFG_W-1:0] TIMEOUT_RST = 24'd96000;
	localparam logic [TCFG_W-1:0] MIN_RST     = 24'd48000;
	localparam logic [TCFG_W-1:0] MAX_RST     = 24'd1440000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD,
		REG_TIMEOUT,
		REG_MIN_SPEECH,
		REG_MAX_SPEECH
	} reg_idx_t;

	typedef enum logic [2:0] {
		EV_NONE,
		EV_KEPT,
		EV_DROPPED,
		EV_FORCED,
		EV_FLUSHED
	} seg_event_t;

	// timing registers seen by the back end
	typedef struct packed {
		logic [TCFG_W-1:0] silence_timeout;
		logic [TCFG_W-1:0] min_speech;
		logic [TCFG_W-1:0] max_speech;
	} seg_cfg_t;

	typedef struct packed {
		logic                 packet_silent;
		logic                 in_speech;
		seg_event_t           segment_event;
		logic [LEN_W-1:0]     segment_length;
	} seg_result_t;

endpackage

// ===== rtl/esseg_front.sv =====
// ----------------------------------------------------------------------------
// esseg_front
// squares samples, gathers packet energy and threshold limit, pushes packet ends
// ----------------------------------------------------------------------------
module esseg_front #(
	parameter int unsigned PACKET_MAX = esseg_pkg::PACKET_MAX_DEF,
	parameter int unsigned CW = $clog2(PACKET_MAX + 1),
	parameter int unsigned EW = esseg_pkg::SQ_W + $clog2(PACKET_MAX),
	parameter int unsigned LW = esseg_pkg::THR_SQ_W + $clog2(PACKET_MAX)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                in_flush,
	input  logic signed [esseg_pkg::SAMPLE_W-1:0] in_sample,
	input  logic                                in_last,
	input  logic                                in_src_silent,
	input  logic [esseg_pkg::THR_W-1:0]         thr,
	input  logic                                q_full,
	output logic                                push,
	output logic                                push_flush,
	output logic                                push_src_silent,
	output logic [CW-1:0]                       push_count,
	output logic [EW-1:0]                       push_energy,
	output logic [LW-1:0]                       push_limit
);

	localparam int unsigned TSW = esseg_pkg::THR_SQ_W;

	logic [esseg_pkg::THR_SQ_W-1:0] thr_sq_q;
	logic signed [31:0]             sample_sq;
	logic                           valid_s1;
	logic                           flush_s1;
	logic                           last_s1;
	logic                           src_s1;
	logic [esseg_pkg::SQ_W-1:0]     sq_s1;
	logic [EW-1:0]                  energy_q;
	logic [LW-1:0]                  limit_q;
	logic [CW-1:0]                  count_q;
	logic [CW-1:0]                  count_nx;
	logic [EW-1:0]                  energy_nx;
	logic [LW-1:0]                  limit_nx;
	logic                           ends_s1;
	logic                           adv_s1;

	assign sample_sq = 32'(in_sample) * 32'(in_sample);

	always_ff @(posedge clk) begin
		thr_sq_q <= TSW'(thr) * TSW'(thr);
	end

	assign count_nx  = count_q + CW'(1);
	assign energy_nx = energy_q + EW'(sq_s1);
	assign limit_nx  = limit_q + LW'(thr_sq_q);
	assign ends_s1   = flush_s1 || last_s1 || (count_nx == CW'(PACKET_MAX));
	assign adv_s1    = !valid_s1 || !ends_s1 || !q_full;
	assign in_ready  = adv_s1;

	assign push            = valid_s1 && ends_s1 && !q_full;
	assign push_flush      = flush_s1;
	assign push_src_silent = src_s1;
	assign push_count      = count_nx;
	assign push_energy     = energy_nx;
	assign push_limit      = limit_nx;

	// square stage, payload only
	always_ff @(posedge clk) begin
		if (in_valid && adv_s1) begin
			flush_s1 <= in_flush;
			last_s1  <= in_last;
			src_s1   <= in_src_silent;
			if (esseg_pkg::SAMPLE_BITS == 16) begin
				sq_s1 <= sample_sq[esseg_pkg::SQ_W-1:0];
			end else begin
				sq_s1 <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			energy_q <= '0;
			limit_q  <= '0;
			count_q  <= '0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (valid_s1 && adv_s1) begin
				if (ends_s1) begin
					energy_q <= '0;
					limit_q  <= '0;
					count_q  <= '0;
				end else begin
					energy_q <= energy_nx;
					limit_q  <= limit_nx;
					count_q  <= count_nx;
				end
			end
		end
	end

endmodule

// ===== rtl/esseg_queue.sv =====
// ----------------------------------------------------------------------------
// esseg_queue
// small register queue of finished packets between front and back
// ----------------------------------------------------------------------------
module esseg_queue #(
	parameter int unsigned W     = 8,
	parameter int unsigned DEPTH = esseg_pkg::QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned NW = $clog2(DEPTH + 1);

	logic [W-1:0]  entry_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [NW-1:0] fill_q;

	assign full     = (fill_q == NW'(DEPTH));
	assign empty    = (fill_q == '0);
	assign pop_data = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + NW'(1);
				2'b01:   fill_q <= fill_q - NW'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== rtl/esseg_back.sv =====
// ----------------------------------------------------------------------------
// esseg_back
// judges each packet, runs the speech/silence tracker, holds the result
// ----------------------------------------------------------------------------
module esseg_back #(
	parameter int unsigned CW = 13,
	parameter int unsigned EW = 43,
	parameter int unsigned LW = 44
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	output logic                   pop,
	input  logic                   e_flush,
	input  logic                   e_src_silent,
	input  logic [CW-1:0]          e_count,
	input  logic [EW-1:0]          e_energy,
	input  logic [LW-1:0]          e_limit,
	input  esseg_pkg::seg_cfg_t    cfg,
	output logic                   res_valid,
	input  logic                   res_ready,
	output esseg_pkg::seg_result_t res
);

	localparam int unsigned TW = esseg_pkg::TIME_W;
	localparam int unsigned SW = esseg_pkg::LEN_W;

	logic                    open_q;
	logic [TW-1:0]           sil_q;
	logic [TW-1:0]           sp_q;
	logic [SW-1:0]           seg_q;
	logic                    out_valid_q;
	esseg_pkg::seg_result_t  out_q;

	logic                    silent;
	logic [TW:0]             sil_sum;
	logic [TW:0]             sp_sum;
	logic [SW:0]             seg_sum;
	logic [TW-1:0]           sil_sat;
	logic [TW-1:0]           sp_sat;
	logic [SW-1:0]           seg_sat;
	logic                    open_n;
	logic [TW-1:0]           sil_n;
	logic [TW-1:0]           sp_n;
	logic [SW-1:0]           seg_n;
	logic                    emit;
	esseg_pkg::seg_result_t  res_n;

	assign pop = !q_empty && (!out_valid_q || res_ready);

	assign silent  = e_src_silent || (LW'(e_energy) < e_limit);
	assign sil_sum = {1'b0, sil_q} + (TW + 1)'(e_count);
	assign sp_sum  = {1'b0, sp_q} + (TW + 1)'(e_count);
	assign seg_sum = {1'b0, seg_q} + (SW + 1)'(e_count);
	assign sil_sat = sil_sum[TW] ? '1 : sil_sum[TW-1:0];
	assign sp_sat  = sp_sum[TW] ? '1 : sp_sum[TW-1:0];
	assign seg_sat = seg_sum[SW] ? '1 : seg_sum[SW-1:0];

	always_comb begin
		open_n = open_q;
		sil_n  = sil_q;
		sp_n   = sp_q;
		seg_n  = seg_sat;
		emit   = 1'b1;
		res_n.packet_silent  = silent;
		res_n.in_speech      = 1'b0;
		res_n.segment_event  = esseg_pkg::EV_NONE;
		res_n.segment_length = '0;
		if (e_flush) begin
			emit = open_q && (sp_q >= TW'(cfg.min_speech));
			res_n.packet_silent  = 1'b0;
			res_n.segment_event  = esseg_pkg::EV_FLUSHED;
			res_n.segment_length = seg_q;
			open_n = 1'b0;
			sil_n  = '0;
			sp_n   = '0;
			seg_n  = '0;
		end else if (silent) begin
			sil_n = sil_sat;
			if (open_q && (sil_sat >= TW'(cfg.silence_timeout))) begin
				res_n.segment_event  = (sp_q >= TW'(cfg.min_speech)) ?
					esseg_pkg::EV_KEPT : esseg_pkg::EV_DROPPED;
				res_n.segment_length = seg_sat;
				seg_n  = '0;
				open_n = 1'b0;
				sp_n   = '0;
			end
		end else begin
			sil_n = '0;
			if (!open_q) begin
				open_n = 1'b1;
				sp_n   = '0;
			end else if (sp_sat >= TW'(cfg.max_speech)) begin
				res_n.segment_event  = esseg_pkg::EV_FORCED;
				res_n.segment_length = seg_sat;
				seg_n  = '0;
				open_n = 1'b0;
				sp_n   = '0;
			end else begin
				sp_n = sp_sat;
			end
		end
		if (!e_flush) begin
			res_n.in_speech = open_n;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= 1'b0;
			sil_q       <= '0;
			sp_q        <= '0;
			seg_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				open_q      <= open_n;
				sil_q       <= sil_n;
				sp_q        <= sp_n;
				seg_q       <= seg_n;
				out_valid_q <= emit;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

// ===== rtl/energy_speech_segmenter.sv =====
// ----------------------------------------------------------------------------
// energy_speech_segmenter
// energy-based speech segmenter over a stream of 16-bit pcm samples
// ----------------------------------------------------------------------------
// Takes one sample transaction per clock unless stalled. The front end squares
// each sample in one multiplier stage and adds it into the packet energy, and
// in parallel adds threshold squared into a limit, so the rms test at the
// packet end is a single compare of energy against limit. Finished packets and
// end-of-stream flushes go through a four-entry queue to the back end, which
// runs the speech/silence tracker and retires one queue entry per clock into
// an output register while that register is free or being read. With the
// queue empty and the output free, a packet's result goes from the square
// stage register through the queue entry into the output register.
// Input stalls only when the queue is full, which happens only while m_tready
// is held low. Sample transactions that do not end a packet give no result; a
// flush gives a result only when an open segment has reached min_speech.
// Configuration writes take effect on the next clock, the squared threshold
// after a further register, and are meant for an idle block.
// ----------------------------------------------------------------------------
module energy_speech_segmenter #(
	parameter int unsigned PACKET_MAX  = esseg_pkg::PACKET_MAX_DEF,
	parameter int unsigned QUEUE_DEPTH = esseg_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// sample stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [esseg_pkg::S_DATA_W-1:0]    s_tdata,   // sample[15:0], source_silent[16], zero pad
	input  logic                              s_tlast,   // last_in_packet
	input  logic                              s_tuser,   // kind: 0 sample, 1 end-of-stream flush
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [esseg_pkg::M_DATA_W-1:0]    m_tdata,   // packet_silent[0], in_speech[1],
	                                                     // segment_event[4:2], segment_length[30:5]
	// configuration writes
	input  logic                              cfg_we,
	input  logic [esseg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [esseg_pkg::CFG_W-1:0]       cfg_data
);

	// widths of the packet sample count, energy sum and threshold limit
	localparam int unsigned CW = $clog2(PACKET_MAX + 1);
	localparam int unsigned EW = esseg_pkg::SQ_W + $clog2(PACKET_MAX);
	localparam int unsigned LW = esseg_pkg::THR_SQ_W + $clog2(PACKET_MAX);
	localparam int unsigned QW = 2 + CW + EW + LW;

	logic [esseg_pkg::THR_W-1:0] thr_q;
	esseg_pkg::seg_cfg_t         cfg_q;

	logic                        push;
	logic                        push_flush;
	logic                        push_src_silent;
	logic [CW-1:0]               push_count;
	logic [EW-1:0]               push_energy;
	logic [LW-1:0]               push_limit;
	logic                        q_full;
	logic                        q_empty;
	logic                        pop;
	logic [QW-1:0]               q_wdata;
	logic [QW-1:0]               q_rdata;
	esseg_pkg::seg_result_t      res;

	// configuration registers, reset to their documented defaults
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q                 <= esseg_pkg::THR_RST;
			cfg_q.silence_timeout <= esseg_pkg::TIMEOUT_RST;
			cfg_q.min_speech      <= esseg_pkg::MIN_RST;
			cfg_q.max_speech      <= esseg_pkg::MAX_RST;
		end else if (cfg_we) begin
			case (esseg_pkg::reg_idx_t'(cfg_index))
				esseg_pkg::REG_THRESHOLD:  thr_q <= cfg_data[esseg_pkg::THR_W-1:0];
				esseg_pkg::REG_TIMEOUT:    cfg_q.silence_timeout <= cfg_data;
				esseg_pkg::REG_MIN_SPEECH: cfg_q.min_speech <= cfg_data;
				esseg_pkg::REG_MAX_SPEECH: cfg_q.max_speech <= cfg_data;
				default: ;
			endcase
		end
	end

	// front end: square, accumulate, detect packet end
	esseg_front #(
		.PACKET_MAX (PACKET_MAX),
		.CW         (CW),
		.EW         (EW),
		.LW         (LW)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.in_flush        (s_tuser),
		.in_sample       (s_tdata[esseg_pkg::SAMPLE_W-1:0]),
		.in_last         (s_tlast),
		.in_src_silent   (s_tdata[esseg_pkg::SAMPLE_W]),
		.thr             (thr_q),
		.q_full          (q_full),
		.push            (push),
		.push_flush      (push_flush),
		.push_src_silent (push_src_silent),
		.push_count      (push_count),
		.push_energy     (push_energy),
		.push_limit      (push_limit)
	);

	// queue entry: limit, energy, count, source silent flag, flush flag
	assign q_wdata = {push_limit, push_energy, push_count, push_src_silent, push_flush};

	esseg_queue #(
		.W     (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	// back end: packet judgment and segment tracking
	esseg_back #(
		.CW (CW),
		.EW (EW),
		.LW (LW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.pop          (pop),
		.e_flush      (q_rdata[0]),
		.e_src_silent (q_rdata[1]),
		.e_count      (q_rdata[2 +: CW]),
		.e_energy     (q_rdata[2 + CW +: EW]),
		.e_limit      (q_rdata[2 + CW + EW +: LW]),
		.cfg          (cfg_q),
		.res_valid    (m_tvalid),
		.res_ready    (m_tready),
		.res          (res)
	);

	// result packing, zero pad in the top bit
	assign m_tdata = {1'b0, res.segment_length, res.segment_event, res.in_speech,
		res.packet_silent};

endmodule

// ===== tb/tb_energy_speech_segmenter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_energy_speech_segmenter
// self-checking testbench of the energy speech segmenter
// ----------------------------------------------------------------------------
// Sends pcm sample and flush transactions into the sample stream and keeps
// its own copy of the packet energy test and of the speech/silence tracker.
// Each accepted transaction is run through that copy and the reports it
// yields are queued. Every result transaction is compared field by field with
// the oldest queued report. Directed tests cover register defaults,
// threshold boundaries and every kind of segment end.
// Random phases then run under several register settings with random gaps
// on the input and random back-pressure on the output.
// ----------------------------------------------------------------------------
module tb_energy_speech_segmenter;

	localparam int STALL_LIMIT     = 2000;  // cycles with no transaction at all
	localparam int SETTLE_CYCLES   = 8;     // lets the pipe empty after the last report
	localparam int ITEMS_PER_PHASE = 100;
	localparam int RANDOM_PHASES   = 8;
	localparam longint unsigned TIME_MAX = (64'd1 << esseg_pkg::TIME_W) - 1;
	localparam longint unsigned LEN_MAX  = (64'd1 << esseg_pkg::LEN_W) - 1;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [esseg_pkg::S_DATA_W-1:0]   s_tdata = '0;   // sample[15:0], source_silent[16], zero pad
	logic                             s_tlast = 1'b0; // last_in_packet
	logic                             s_tuser = 1'b0; // kind: 0 sample, 1 end-of-stream flush
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [esseg_pkg::M_DATA_W-1:0]   m_tdata;        // packet_silent[0], in_speech[1],
	                                                  // segment_event[4:2], segment_length[30:5]
	logic                             cfg_we = 1'b0;
	esseg_pkg::reg_idx_t              cfg_index = esseg_pkg::REG_THRESHOLD;
	logic [esseg_pkg::CFG_W-1:0]      cfg_data = '0;

	// register mirror
	logic [esseg_pkg::THR_W-1:0]      thr_r;
	logic [esseg_pkg::TCFG_W-1:0]     timeout_r;
	logic [esseg_pkg::TCFG_W-1:0]     min_speech_r;
	logic [esseg_pkg::TCFG_W-1:0]     max_speech_r;

	// tracker mirror
	longint unsigned       pk_energy;
	longint unsigned       pk_count;
	bit                    seg_open;
	longint unsigned       quiet_time;
	longint unsigned       talk_time;
	longint unsigned       seg_len;

	esseg_pkg::seg_result_t seg_reports_due[$];

	bit                    gaps_on = 1'b1;
	bit                    stalls_on = 1'b1;
	int                    stall_left = 0;
	int                    quiet_cycles = 0;
	int                    error_count = 0;
	int                    sample_count = 0;
	int                    packet_count = 0;
	int                    flush_count = 0;
	int                    result_count = 0;
	int                    events_seen[5] = '{default: 0};

	energy_speech_segmenter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------

	function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b,
			longint unsigned lim);
		return (a + b > lim) ? lim : a + b;
	endfunction

	function automatic void clear_tracker();
		pk_energy  = 0;
		pk_count   = 0;
		seg_open   = 1'b0;
		quiet_time = 0;
		talk_time  = 0;
		seg_len    = 0;
	endfunction

	// advance the mirror by one accepted transaction, queue any report it gives
	function automatic void track_item(bit flush, logic [15:0] smp, bit eop, bit src_quiet);
		esseg_pkg::seg_result_t rpt;
		longint unsigned mag;
		longint unsigned cnt;
		bit quiet;
		rpt.packet_silent  = 1'b0;
		rpt.in_speech      = 1'b0;
		rpt.segment_event  = esseg_pkg::EV_NONE;
		rpt.segment_length = '0;
		if (flush) begin
			// an open segment long enough is reported, everything else is dropped
			if (seg_open && talk_time >= min_speech_r) begin
				rpt.segment_event  = esseg_pkg::EV_FLUSHED;
				rpt.segment_length = seg_len[esseg_pkg::LEN_W-1:0];
				seg_reports_due.push_back(rpt);
			end
			clear_tracker();
			return;
		end
		mag = smp[15] ? 65536 - smp : smp;
		pk_energy += mag * mag;
		pk_count++;
		// packet ends on tlast or when it hits the length cap
		if (!eop && pk_count < esseg_pkg::PACKET_MAX_DEF)
			return;
		cnt = pk_count;
		quiet = src_quiet || (pk_energy < longint'(thr_r) * thr_r * cnt);
		seg_len = sat_add(seg_len, cnt, LEN_MAX);
		if (quiet) begin
			// silence keeps counting even with no segment open
			quiet_time = sat_add(quiet_time, cnt, TIME_MAX);
			if (seg_open && quiet_time >= timeout_r) begin
				rpt.segment_event  = (talk_time >= min_speech_r) ? esseg_pkg::EV_KEPT
					: esseg_pkg::EV_DROPPED;
				rpt.segment_length = seg_len[esseg_pkg::LEN_W-1:0];
				seg_len   = 0;
				seg_open  = 1'b0;
				talk_time = 0;
			end
		end else begin
			if (!seg_open) begin
				// the opening packet adds nothing to the speech time
				seg_open  = 1'b1;
				talk_time = 0;
			end else begin
				talk_time = sat_add(talk_time, cnt, TIME_MAX);
				if (talk_time >= max_speech_r) begin
					rpt.segment_event  = esseg_pkg::EV_FORCED;
					rpt.segment_length = seg_len[esseg_pkg::LEN_W-1:0];
					seg_len   = 0;
					seg_open  = 1'b0;
					talk_time = 0;
				end
			end
			quiet_time = 0;
		end
		pk_energy = 0;
		pk_count  = 0;
		packet_count++;
		rpt.packet_silent = quiet;
		rpt.in_speech     = seg_open;
		seg_reports_due.push_back(rpt);
	endfunction

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------

	// sample of magnitude level +- spread/2 and random sign, level < 0 is noise
	function automatic logic [15:0] pcm_value(int level, int spread);
		int mag;
		if (level < 0)
			return 16'($urandom);
		mag = level + int'($urandom_range(0, spread)) - spread / 2;
		if (mag < 0)
			mag = 0;
		if (mag > 32768)
			mag = 32768;
		if ($urandom_range(0, 1))
			return 16'(-mag);
		return (mag > 32767) ? 16'h7fff : 16'(mag);
	endfunction

	// one sample or flush transaction, random gap in front of it
	task automatic send_item(bit flush, logic [15:0] smp, bit eop, bit src_quiet);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= flush;
		s_tlast  <= eop;
		s_tdata  <= {{(esseg_pkg::S_DATA_W - 17){1'b0}}, src_quiet, smp};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (flush)
			flush_count++;
		else
			sample_count++;
		track_item(flush, smp, eop, src_quiet);
	endtask

	// source_silent only counts on the closing sample, noise elsewhere
	task automatic send_packet(int len, int level, int spread, bit src_quiet);
		for (int i = 0; i < len; i++)
			send_item(1'b0, pcm_value(level, spread), i == len - 1,
				(i == len - 1) ? src_quiet : bit'($urandom_range(0, 1)));
	endtask

	task automatic send_flush();
		send_item(1'b1, 16'($urandom), bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)));
	endtask

	// hold off the input until every queued report is out, then let the pipe empty
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (seg_reports_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(esseg_pkg::reg_idx_t idx, logic [esseg_pkg::CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// only called at a packet boundary with the block idle
	task automatic load_config(logic [esseg_pkg::THR_W-1:0] thr,
			logic [esseg_pkg::TCFG_W-1:0] timeout, logic [esseg_pkg::TCFG_W-1:0] min_sp,
			logic [esseg_pkg::TCFG_W-1:0] max_sp);
		wait_drained();
		write_reg(esseg_pkg::REG_THRESHOLD,
			{{(esseg_pkg::CFG_W - esseg_pkg::THR_W){1'b0}}, thr});
		write_reg(esseg_pkg::REG_TIMEOUT, timeout);
		write_reg(esseg_pkg::REG_MIN_SPEECH, min_sp);
		write_reg(esseg_pkg::REG_MAX_SPEECH, max_sp);
		cfg_we       <= 1'b0;
		thr_r        = thr;
		timeout_r    = timeout;
		min_speech_r = min_sp;
		max_speech_r = max_sp;
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// reset values: loud packets open a segment, source flag forces silence,
	// flush of a short segment gives nothing
	task automatic test_default_levels();
		send_packet(3, 32767, 0, 1'b0);
		send_packet(2, 32768, 0, 1'b0);
		send_packet(2, 0, 0, 1'b0);
		send_packet(2, 32767, 0, 1'b1);
		send_packet(1, -1, 0, 1'b0);
		send_flush();
	endtask

	// rms exactly at the threshold is not silence, zero threshold never is
	task automatic test_threshold_edges();
		load_config(16'd100, esseg_pkg::TIMEOUT_RST, esseg_pkg::MIN_RST, esseg_pkg::MAX_RST);
		send_packet(2, 100, 0, 1'b0);
		send_packet(2, 99, 0, 1'b0);
		send_packet(1, 101, 0, 1'b0);
		load_config(16'd0, esseg_pkg::TIMEOUT_RST, esseg_pkg::MIN_RST, esseg_pkg::MAX_RST);
		send_packet(2, 0, 0, 1'b0);
		load_config(16'hffff, esseg_pkg::TIMEOUT_RST, esseg_pkg::MIN_RST, esseg_pkg::MAX_RST);
		send_packet(2, 32768, 0, 1'b0);
		load_config(16'd32768, esseg_pkg::TIMEOUT_RST, esseg_pkg::MIN_RST, esseg_pkg::MAX_RST);
		send_packet(2, 32768, 0, 1'b0);
		send_flush();
	endtask

	// kept, silence after an end, dropped short, forced at max, flushed
	task automatic test_segment_ends();
		load_config(16'd1000, 24'd2, 24'd3, 24'd6);
		send_packet(1, 20000, 0, 1'b0);  // opens
		send_packet(2, 20000, 0, 1'b0);
		send_packet(1, 0, 0, 1'b0);
		send_packet(2, 20000, 0, 1'b0);  // silence count restarts
		send_packet(2, 0, 0, 1'b0);      // timeout, long enough: kept
		send_packet(1, 0, 0, 1'b0);      // silence grows with nothing open
		send_packet(1, 20000, 0, 1'b0);
		send_packet(2, 0, 0, 1'b0);      // too short: dropped
		send_packet(1, 20000, 0, 1'b0);
		send_packet(3, 20000, 0, 1'b0);
		send_packet(3, 20000, 0, 1'b0);  // reaches max: forced
		send_packet(1, 20000, 0, 1'b0);
		send_packet(3, 20000, 0, 1'b0);
		send_flush();                    // open and long enough: flushed
	endtask

	task automatic test_random_traffic();
		int sent;
		int pick;
		int len;
		int level;
		int spread;
		int t;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph == 0)
				load_config(16'($urandom_range(0, 3000)), '0, '0, '0);
			else if (ph == 1)
				load_config(16'($urandom), '1, '1, '1);
			else
				load_config(($urandom_range(0, 3) == 0) ? 16'($urandom)
						: 16'($urandom_range(50, 4000)),
					24'($urandom_range(0, 60)), 24'($urandom_range(0, 40)),
					24'($urandom_range(1, 150)));
			// the last phase runs with no gaps and no back-pressure
			if (ph == RANDOM_PHASES - 1) begin
				gaps_on   = 1'b0;
				stalls_on = 1'b0;
			end
			t = thr_r;
			sent = sample_count + flush_count;
			while (sample_count + flush_count - sent < ITEMS_PER_PHASE) begin
				if (ph == 3 && sample_count + flush_count - sent == ITEMS_PER_PHASE / 2)
					wait_drained();
				pick = $urandom_range(0, 99);
				if (pick < 4) begin
					send_flush();
				end else if (pick < 9) begin
					// packet cut short by a flush
					repeat ($urandom_range(1, 3))
						send_item(1'b0, pcm_value(-1, 0), 1'b0, bit'($urandom_range(0, 1)));
					send_flush();
				end else begin
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48)
						: $urandom_range(1, 12);
					case ($urandom_range(0, 3))
						0: begin
							level  = -1;
							spread = 0;
						end
						1: begin
							level  = $urandom_range(0, t / 4);
							spread = t / 8;
						end
						default: begin
							// rms close to the threshold on either side
							level  = t + int'($urandom_range(0, t / 4 + 2)) - (t / 8 + 1);
							spread = t / 16 + 1;
						end
					endcase
					send_packet(len, level, spread, $urandom_range(0, 7) == 0);
				end
			end
			send_flush();
		end
	endtask

	// ------------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------------

	function automatic void check_field(string name, longint unsigned want,
			longint unsigned got);
		if (want != got) begin
			error_count++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d",
				$time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		esseg_pkg::seg_result_t want;
		esseg_pkg::seg_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.packet_silent  = m_tdata[0];
			got.in_speech      = m_tdata[1];
			got.segment_event  = esseg_pkg::seg_event_t'(m_tdata[4:2]);
			got.segment_length = m_tdata[30:5];
			result_count++;
			if (got.segment_event <= esseg_pkg::EV_FLUSHED)
				events_seen[got.segment_event]++;
			if (seg_reports_due.size() == 0) begin
				error_count++;
				$display("%0t ns: result transaction with nothing expected,",
					$time, " expected none, actual %h", m_tdata);
			end else begin
				want = seg_reports_due.pop_front();
				check_field("packet_silent", want.packet_silent, got.packet_silent);
				check_field("in_speech", want.in_speech, got.in_speech);
				check_field("segment_event", want.segment_event, got.segment_event);
				check_field("segment_length", want.segment_length, got.segment_length);
			end
		end
	end

	// random back-pressure bursts on the output
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= (stall_left == 1);
		end else if (stalls_on && $urandom_range(0, 5) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(1, 8);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watchdog: too long without any transaction on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles at %0t ns",
				STALL_LIMIT, $time);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------

	initial begin
		thr_r        = esseg_pkg::THR_RST;
		timeout_r    = esseg_pkg::TIMEOUT_RST;
		min_speech_r = esseg_pkg::MIN_RST;
		max_speech_r = esseg_pkg::MAX_RST;
		clear_tracker();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_default_levels();
		test_threshold_edges();
		test_segment_ends();
		test_random_traffic();

		wait_drained();
		$display("covered %0d samples, %0d packets, %0d flushes, %0d results checked",
			sample_count, packet_count, flush_count, result_count);
		$display("segment ends seen: kept %0d, dropped %0d, forced %0d, flushed %0d",
			events_seen[esseg_pkg::EV_KEPT], events_seen[esseg_pkg::EV_DROPPED],
			events_seen[esseg_pkg::EV_FORCED], events_seen[esseg_pkg::EV_FLUSHED]);
		if (error_count == 0 && seg_reports_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/esseg_pkg.sv
rtl/esseg_front.sv
rtl/esseg_queue.sv
rtl/esseg_back.sv
rtl/energy_speech_segmenter.sv
tb/tb_energy_speech_segmenter.sv
